// ----- sv/ccm_pkg.sv -----
`timescale 1ns / 1ps
package ccm_pkg;
  localparam int NumVars = 1024;
  localparam int MaxLen = 64;
  localparam int VarW = 10;
  localparam int LenW = 7;
  localparam int PosW = 6;
  localparam int LabW = 12;
  localparam int MarkW = 11;
  localparam int CntW = 11;
  localparam int EntW = LabW + 1;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic            opcode;
    logic [VarW-1:0] var_index;
    logic            clause_end;
  } ccm_in_t;

  typedef struct packed {
    logic [10:0] clause_label;
    logic [10:0] live_components;
    logic        already_joined;
    logic        truncated;
  } ccm_out_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SAME_RD,
    ST_SAME_LK,
    ST_SAME_CHK,
    ST_MARK_RD,
    ST_MARK_LK,
    ST_MARK_CHK,
    ST_MARK_WR,
    ST_JOIN_RD,
    ST_JOIN_LK,
    ST_JOIN_WR,
    ST_WALK_RD,
    ST_WALK_LK,
    ST_WALK_WR,
    ST_MCLR,
    ST_DONE
  } ccm_state_t;
endpackage

// ----- sv/ccm_ram.sv -----
`timescale 1ns / 1ps
module ccm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/clause_component_merger_unit.sv -----
`timescale 1ns / 1ps
// Literals are taken one per cycle while busy is low; a clause end then keeps
// busy high while a sequencer reads the clause buffer and the label table
// through memories with registered reads: a shared-label check of each
// buffered literal, a pass that marks the touched components and a pass that
// labels the clause. When components merge or a fresh component is formed, a
// walk of the label table and a clearing of the marks are added.
// After reset or a clear the block clears its tables with busy high. The result
// strobe out_valid lasts one cycle and cannot be stalled.
module clause_component_merger_unit
  import ccm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ccm_in_t  in_req,
  output logic     out_valid,
  output ccm_out_t out_res
);
  ccm_state_t state_r, state_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic [LenW-1:0] idx_r, idx_nxt;
  logic [MarkW-1:0] sweep_r, sweep_nxt;
  logic ovf_r, ovf_nxt;
  logic [LabW-1:0] next_r, next_nxt;
  logic [CntW-1:0] live_r, live_nxt;
  logic [CntW-1:0] touched_r, touched_nxt;
  logic [LabW-1:0] first_r, first_nxt;
  logic [VarW-1:0] cur_r, cur_nxt;
  logic joined_r, joined_nxt;
  ccm_out_t res_r, res_nxt;
  logic val_r, val_nxt;

  logic bwe, lwe, mwe;
  logic [PosW-1:0] bwa, bra;
  logic [VarW-1:0] bwd, brd, lwa, lra;
  logic [EntW-1:0] lwd, lrd;
  logic [MarkW-1:0] mwa, mra;
  logic mwd, mrd;

  ccm_ram #(.Width(VarW), .Depth(MaxLen)) u_buf (
    .clk, .we(bwe), .waddr(bwa), .wdata(bwd), .raddr(bra), .rdata(brd));
  ccm_ram #(.Width(EntW), .Depth(NumVars)) u_lab (
    .clk, .we(lwe), .waddr(lwa), .wdata(lwd), .raddr(lra), .rdata(lrd));
  ccm_ram #(.Width(1), .Depth(2 * NumVars)) u_mark (
    .clk, .we(mwe), .waddr(mwa), .wdata(mwd), .raddr(mra), .rdata(mrd));

  logic accept, last;
  logic lv;
  logic [LabW-1:0] ll;
  logic lmark;
  logic hit;
  logic [CntW-1:0] touched_sum;

  assign busy = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign last = (idx_r + 1'b1 == len_r);
  assign lv = lrd[LabW];
  assign ll = lrd[LabW-1:0];
  assign lmark = (ll[LabW-1] == 1'b0) && mrd;
  assign hit = lv && !lmark;
  assign touched_sum = touched_r + CntW'(hit);
  assign out_valid = val_r;
  assign out_res = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sweep_r == MarkW'(2 * NumVars - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_req.opcode == OP_CLEAR) state_nxt = ST_CLEAR;
          else if (in_req.clause_end) begin
            if (len_r == '0 && 1'b0) state_nxt = ST_DONE;
            else state_nxt = ST_SAME_RD;
          end
        end
      end
      ST_SAME_RD: state_nxt = ST_SAME_LK;
      ST_SAME_LK: state_nxt = ST_SAME_CHK;
      ST_SAME_CHK: begin
        if (!lv || (idx_r != '0 && ll != first_r)) state_nxt = ST_MARK_RD;
        else if (last) state_nxt = ST_DONE;
        else state_nxt = ST_SAME_RD;
      end
      ST_MARK_RD: state_nxt = ST_MARK_LK;
      ST_MARK_LK: state_nxt = ST_MARK_CHK;
      ST_MARK_CHK: state_nxt = ST_MARK_WR;
      ST_MARK_WR: begin
        if (!last) state_nxt = ST_MARK_RD;
        else if (touched_sum == CntW'(1)) state_nxt = ST_JOIN_RD;
        else state_nxt = ST_WALK_RD;
      end
      ST_JOIN_RD: state_nxt = ST_JOIN_LK;
      ST_JOIN_LK: state_nxt = ST_JOIN_WR;
      ST_JOIN_WR: state_nxt = last ? ST_DONE : ST_JOIN_RD;
      ST_WALK_RD: state_nxt = ST_WALK_LK;
      ST_WALK_LK: state_nxt = ST_WALK_WR;
      ST_WALK_WR: begin
        if (sweep_r == MarkW'(NumVars - 1)) state_nxt = ST_JOIN_RD;
        else state_nxt = ST_WALK_RD;
      end
      ST_MCLR: if (sweep_r == MarkW'(2 * NumVars - 1)) state_nxt = ST_IDLE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    len_nxt = len_r;
    idx_nxt = idx_r;
    sweep_nxt = sweep_r;
    ovf_nxt = ovf_r;
    next_nxt = next_r;
    live_nxt = live_r;
    touched_nxt = touched_r;
    first_nxt = first_r;
    cur_nxt = cur_r;
    joined_nxt = joined_r;
    res_nxt = res_r;
    val_nxt = 1'b0;
    bwe = 1'b0;
    bwa = len_r[PosW-1:0];
    bwd = in_req.var_index;
    bra = idx_r[PosW-1:0];
    lwe = 1'b0;
    lwa = cur_r;
    lwd = {1'b1, first_r};
    lra = brd;
    mwe = 1'b0;
    mwa = sweep_r;
    mwd = 1'b0;
    mra = ll[MarkW-1:0];
    unique case (state_r)
      ST_CLEAR: begin
        lwe = 1'b1;
        lwa = sweep_r[VarW-1:0];
        lwd = {1'b0, {LabW{1'b1}}};
        mwe = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
        len_nxt = '0;
        ovf_nxt = 1'b0;
        next_nxt = '0;
        live_nxt = '0;
      end
      ST_IDLE: begin
        idx_nxt = '0;
        touched_nxt = '0;
        joined_nxt = 1'b0;
        sweep_nxt = '0;
        if (accept && in_req.opcode == OP_ADD) begin
          if (len_r < LenW'(MaxLen)) begin
            bwe = 1'b1;
            len_nxt = len_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      ST_SAME_RD: ;
      ST_SAME_LK: ;
      ST_SAME_CHK: begin
        if (idx_r == '0) first_nxt = ll;
        if (!lv || (idx_r != '0 && ll != first_r)) begin
          idx_nxt = '0;
        end else if (last) begin
          joined_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_MARK_RD: ;
      ST_MARK_LK: cur_nxt = brd;
      ST_MARK_CHK: ;
      ST_MARK_WR: begin
        lra = cur_r;
        mra = ll[MarkW-1:0];
        if (hit) begin
          mwe = (ll[LabW-1] == 1'b0);
          mwa = ll[MarkW-1:0];
          mwd = 1'b1;
          if (touched_r == '0) first_nxt = ll;
          touched_nxt = touched_r + 1'b1;
        end
        if (last) begin
          idx_nxt = '0;
          if (touched_sum != CntW'(1)) begin
            first_nxt = next_r;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_JOIN_RD: ;
      ST_JOIN_LK: cur_nxt = brd;
      ST_JOIN_WR: begin
        lra = cur_r;
        lwa = cur_r;
        lwe = !lv;
        if (last) begin
          if (touched_r == CntW'(1)) begin
            mwe = (first_r[LabW-1] == 1'b0);
            mwa = first_r[MarkW-1:0];
          end else begin
            live_nxt = live_r - touched_r + 1'b1;
            next_nxt = next_r + 1'b1;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_WALK_RD: lra = sweep_r[VarW-1:0];
      ST_WALK_LK: lra = sweep_r[VarW-1:0];
      ST_WALK_WR: begin
        lra = sweep_r[VarW-1:0];
        lwa = sweep_r[VarW-1:0];
        lwe = lv && lmark;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == MarkW'(NumVars - 1)) sweep_nxt = '0;
      end
      ST_MCLR: begin
        mwe = 1'b1;
        sweep_nxt = sweep_r + 1'b1;
      end
      ST_DONE: begin
        val_nxt = 1'b1;
        res_nxt.clause_label = first_r[10:0];
        res_nxt.live_components = live_r;
        res_nxt.already_joined = joined_r;
        res_nxt.truncated = ovf_r;
        len_nxt = '0;
        ovf_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  ccm_state_t st_after;
  always_comb begin
    st_after = state_nxt;
    if (state_r == ST_DONE && !joined_r && touched_r != CntW'(1)) st_after = ST_MCLR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      sweep_r <= '0;
      len_r <= '0;
      ovf_r <= 1'b0;
      next_r <= '0;
      live_r <= '0;
      val_r <= 1'b0;
      idx_r <= '0;
      touched_r <= '0;
      joined_r <= 1'b0;
    end else begin
      state_r <= st_after;
      sweep_r <= (state_r == ST_DONE) ? '0 : sweep_nxt;
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
      next_r <= next_nxt;
      live_r <= live_nxt;
      val_r <= val_nxt;
      idx_r <= idx_nxt;
      touched_r <= touched_nxt;
      joined_r <= joined_nxt;
    end
    first_r <= first_nxt;
    cur_r <= cur_nxt;
    res_r <= res_nxt;
  end
endmodule
